/* rtl/core/key_value_table_linear_assert.svh */
// Assertion macros shared by the key/value table RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef KEY_VALUE_TABLE_LINEAR_ASSERT_SVH
`define KEY_VALUE_TABLE_LINEAR_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define KVT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define KVT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/kvt_pkg.sv */
// Package for the key/value table: field widths, op and status codes,
// transaction payload types and the cell chain types. No dependencies.
package kvt_pkg;

    localparam int KVT_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int VAL_W        = 32;
    localparam int COUNT_OUT_W  = 5;

    localparam logic [1:0] OP_SET    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value_in;
    } kvt_req_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [VAL_W-1:0]       value_out;
        logic [COUNT_OUT_W-1:0] entry_count;
    } kvt_rsp_t;

    typedef struct packed {
        logic             fire;
        logic             any_hit;
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } kvt_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } kvt_chain_t;

endpackage

/* rtl/core/kvt_stream_if.sv */
// Valid/ready transaction channel carrying one payload of type T.
// Depends on nothing; payload types come from kvt_pkg at instantiation.
interface kvt_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/kvt_cell.sv */
// One table slot: holds a key/value pair, compares against the broadcast
// key, takes the pair on set and shifts down on remove. Depends on kvt_pkg.
module kvt_cell import kvt_pkg::*; #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic             clk,
    input  kvt_cmd_t         cmd,
    input  logic [CW-1:0]    count,
    input  kvt_chain_t       chain_in,
    output kvt_chain_t       chain_out,
    input  logic [KEY_W-1:0] next_key,
    input  logic [VAL_W-1:0] next_value,
    output logic [KEY_W-1:0] cell_key,
    output logic [VAL_W-1:0] cell_value
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [VAL_W-1:0] value_reg;
    logic [VAL_W-1:0] value_next;
    logic             in_use;
    logic             match;
    logic             at_tail;

    assign in_use  = CW'(IDX) < count;
    assign at_tail = CW'(IDX) == count;
    assign match   = in_use && (key_reg == cmd.key);

    assign chain_out.hit   = chain_in.hit | match;
    assign chain_out.value = chain_in.value | (match ? value_reg : '0);

    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (cmd.fire)
        begin
            unique case (cmd.op)
                OP_SET:
                begin
                    if (match)
                    begin
                        value_next = cmd.value;
                    end
                    else if (!cmd.any_hit && at_tail)
                    begin
                        key_next   = cmd.key;
                        value_next = cmd.value;
                    end
                end
                OP_REMOVE:
                begin
                    if (in_use && chain_out.hit)
                    begin
                        key_next   = next_key;
                        value_next = next_value;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign cell_key   = key_reg;
    assign cell_value = value_reg;

endmodule

/* rtl/core/key_value_table_linear.sv */
// A request is registered when its transaction is accepted; the execute state
// then runs the compare and shift across the cell chain, registers the result
// and waits while an earlier result is held. No new request is taken before it ends.
// Reset: rst_n clears the entry count, the sequencer and the output valid;
// slot contents are left as they are and need no clearing pass.
module key_value_table_linear import kvt_pkg::*; #(
    parameter int CAPACITY = KVT_CAPACITY
) (
    input  logic         clk,
    input  logic         rst_n,
    kvt_stream_if.sink   req,
    kvt_stream_if.source rsp
);

`include "key_value_table_linear_assert.svh"

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    kvt_req_t         req_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    kvt_rsp_t         out_reg;
    kvt_rsp_t         out_next;
    logic             req_fire;
    logic             exec_fire;
    logic             any_hit;
    kvt_cmd_t         cmd;
    kvt_chain_t       chain [CAPACITY+1];
    logic [KEY_W-1:0] cell_key [CAPACITY];
    logic [VAL_W-1:0] cell_value [CAPACITY];

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);

    assign chain[0] = '0;
    assign any_hit  = chain[CAPACITY].hit;

    assign cmd.fire    = exec_fire;
    assign cmd.any_hit = any_hit;
    assign cmd.op      = req_reg.op;
    assign cmd.key     = req_reg.key;
    assign cmd.value   = req_reg.value_in;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_W-1:0] nk;
        logic [VAL_W-1:0] nv;
        if (i == CAPACITY - 1)
        begin : g_last
            assign nk = cell_key[i];
            assign nv = cell_value[i];
        end
        else
        begin : g_mid
            assign nk = cell_key[i+1];
            assign nv = cell_value[i+1];
        end
        kvt_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .count      (count_reg),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .next_key   (nk),
            .next_value (nv),
            .cell_key   (cell_key[i]),
            .cell_value (cell_value[i])
        );
    end

    always_comb
    begin
        count_next         = count_reg;
        out_next.status    = ST_OK;
        out_next.value_out = '0;
        unique case (req_reg.op)
            OP_SET:
            begin
                if (!any_hit)
                begin
                    if (count_reg < CW'(CAPACITY))
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        out_next.status = ST_FULL;
                    end
                end
            end
            OP_REMOVE:
            begin
                if (any_hit)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    out_next.status = ST_NOT_FOUND;
                end
            end
            OP_QUERY:
            begin
                if (any_hit)
                begin
                    out_next.value_out = chain[CAPACITY].value;
                end
                else
                begin
                    out_next.status = ST_NOT_FOUND;
                end
            end
            default:
            begin
            end
        endcase
        out_next.entry_count = COUNT_OUT_W'(count_next);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_reg <= req.data;
        end
        if (exec_fire)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    `KVT_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(CAPACITY),
        "entry count above capacity")
    `KVT_ASSERT_NXT(a_append_grows, clk, rst_n,
        exec_fire && (req_reg.op == OP_SET) && !any_hit && (count_reg < CW'(CAPACITY)),
        count_reg == $past(count_reg) + CW'(1), "append did not grow the table")
    `KVT_ASSERT_IMP(a_full_at_capacity, clk, rst_n,
        out_valid_reg && (out_reg.status == ST_FULL), count_reg == CW'(CAPACITY),
        "full status below capacity")
    `KVT_ASSERT_NXT(a_miss_zero_value, clk, rst_n, exec_fire && !any_hit,
        out_reg.value_out == '0, "value returned without a match")

endmodule
